@@ hw/rtl/urm_pkg.sv @@
`default_nettype none

package urm_pkg;

    localparam int URM_FIFO_DEPTH = 256;

    // item kinds
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_RX    = 2'd2;

    // register byte offsets
    localparam logic [7:0] OFF_SR  = 8'h00;
    localparam logic [7:0] OFF_DR  = 8'h04;
    localparam logic [7:0] OFF_BRR = 8'h08;
    localparam logic [7:0] OFF_CR1 = 8'h0C;
    localparam logic [7:0] OFF_CR2 = 8'h10;
    localparam logic [7:0] OFF_CR3 = 8'h14;

    // bit positions
    localparam int SR_RXNE = 5;
    localparam int SR_TC   = 6;
    localparam int SR_TXE  = 7;
    localparam int CR1_RE  = 2;
    localparam int CR1_TE  = 3;
    localparam int CR1_UE  = 13;

    // requests from the register logic to the receive FIFO
    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic [1:0] pops;
    } fifo_ctrl_t;

    // head view of the receive FIFO; avail is min(2, fill) once settled
    typedef struct packed {
        logic [7:0] head0;
        logic [7:0] head1;
        logic [1:0] avail;
        logic       full;
        logic       settled;
    } fifo_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/urm_in_if.sv @@
`default_nettype none

interface urm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  offset;
    logic [31:0] write_data;
    logic [7:0]  rx_byte;

    modport source (output valid, output func, output offset, output write_data,
                    output rx_byte, input ready);
    modport sink   (input valid, input func, input offset, input write_data,
                    input rx_byte, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/urm_out_if.sv @@
`default_nettype none

interface urm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        rx_dropped;

    modport source (output valid, output read_data, output tx_valid, output tx_byte,
                    output rx_dropped, input ready);
    modport sink   (input valid, input read_data, input tx_valid, input tx_byte,
                    input rx_dropped, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/urm_ram.sv @@
`default_nettype none

module urm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/urm_rx_fifo.sv @@
`default_nettype none

// Receive FIFO: two-entry front buffer in flops ahead of a RAM.
// The front always holds the first min(2, fill) bytes once settled.
module urm_rx_fifo
    import urm_pkg::*;
#(
    parameter int FIFO_DEPTH = URM_FIFO_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire fifo_ctrl_t ctrl,
    output fifo_stat_t  stat
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic [1:0]    cnt_reg, cnt_next;
    logic [CW-1:0] ram_cnt_reg, ram_cnt_next;
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [AW-1:0] rptr_reg, rptr_next;
    logic          pend_reg, pend_next;
    logic [7:0]    front_reg [2];
    logic [7:0]    front_next [2];

    logic          ram_we;
    logic          issue;
    logic [7:0]    ram_rdata;
    logic [CW-1:0] fill;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign fill = CW'(cnt_reg) + ram_cnt_reg;

    assign stat.head0   = front_reg[0];
    assign stat.head1   = front_reg[1];
    assign stat.avail   = cnt_reg;
    assign stat.full    = (fill == CW'(FIFO_DEPTH));
    assign stat.settled = !pend_reg && (cnt_reg == 2'd2 || ram_cnt_reg == '0);

    // refill reads only start while unsettled, so never alongside a push or pop
    assign issue = !pend_reg && cnt_reg != 2'd2 && ram_cnt_reg != '0;

    always_comb
    begin
        front_next[0] = front_reg[0];
        front_next[1] = front_reg[1];
        cnt_next      = cnt_reg;
        ram_we        = 1'b0;

        if (ctrl.push)
        begin
            if (ram_cnt_reg == '0 && cnt_reg != 2'd2)
            begin
                if (cnt_reg == 2'd0)
                begin
                    front_next[0] = ctrl.push_byte;
                end
                else
                begin
                    front_next[1] = ctrl.push_byte;
                end
                cnt_next = cnt_reg + 2'd1;
            end
            else
            begin
                ram_we = 1'b1;
            end
        end

        case (ctrl.pops)
            2'd1:
            begin
                front_next[0] = front_next[1];
                cnt_next      = cnt_next - 2'd1;
            end
            2'd2:
            begin
                cnt_next = cnt_next - 2'd2;
            end
            default:
            begin
            end
        endcase

        // RAM data returns into the first free front slot
        if (pend_reg)
        begin
            if (cnt_reg == 2'd0)
            begin
                front_next[0] = ram_rdata;
            end
            else
            begin
                front_next[1] = ram_rdata;
            end
            cnt_next = cnt_reg + 2'd1;
        end

        ram_cnt_next = ram_cnt_reg;
        if (ram_we)
        begin
            ram_cnt_next = ram_cnt_reg + CW'(1);
        end
        else if (issue)
        begin
            ram_cnt_next = ram_cnt_reg - CW'(1);
        end

        wptr_next = ram_we ? ptr_inc(wptr_reg) : wptr_reg;
        rptr_next = issue ? ptr_inc(rptr_reg) : rptr_reg;
        pend_next = issue;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            ram_cnt_reg <= '0;
            wptr_reg    <= '0;
            rptr_reg    <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            ram_cnt_reg <= ram_cnt_next;
            wptr_reg    <= wptr_next;
            rptr_reg    <= rptr_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg[0] <= front_next[0];
        front_reg[1] <= front_next[1];
    end

    urm_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wptr_reg),
        .wdata (ctrl.push_byte),
        .re    (issue),
        .raddr (rptr_reg),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

@@ hw/rtl/uart_register_model_with_rx_fifo.sv @@
`default_nettype none

// Channel  | Dir | Payload                                         | Transfer
// ---------+-----+-------------------------------------------------+-------------------
// item     | in  | func, offset, write_data, rx_byte               | valid && ready
// result   | out | read_data, tx_valid, tx_byte, rx_dropped        | valid && ready
//
// Items pass the input register, then the register logic into the result register.
// Items stream at one per cycle while the FIFO front buffer is settled and the result
// is not stalled; a byte taken from the FIFO while more sit in the RAM holds the next
// item for the RAM read and its return, as does a data read that takes two bytes with
// two or more in the RAM. Reset clears the control registers and counts; the RAM and
// the data-path registers are not cleared.
// A stalled result holds its register and the input register still takes one item.
module uart_register_model_with_rx_fifo
    import urm_pkg::*;
#(
    parameter int FIFO_DEPTH = URM_FIFO_DEPTH
) (
    input wire logic  clk,
    input wire logic  rst_n,
    urm_in_if.sink    item,
    urm_out_if.source result
);

    // input register
    logic        iv_reg, iv_next;
    logic [1:0]  func_reg;
    logic [7:0]  offset_reg;
    logic [31:0] wdata_reg;
    logic [7:0]  rxb_reg;

    // register file
    logic [31:0] sr_reg, sr_next;
    logic [7:0]  dr_reg, dr_next;
    logic [31:0] brr_reg, brr_next;
    logic [31:0] cr1_reg, cr1_next;
    logic [31:0] cr2_reg, cr2_next;
    logic [31:0] cr3_reg, cr3_next;

    // result register
    logic        ov_reg, ov_next;
    logic [31:0] rd_reg, rd_next;
    logic        txv_reg, txv_next;
    logic [7:0]  txb_reg, txb_next;
    logic        drop_reg, drop_next;

    fifo_ctrl_t  fctrl;
    fifo_stat_t  fstat;
    logic        process;
    logic        accept;

    assign process    = iv_reg && fstat.settled && (!ov_reg || result.ready);
    assign item.ready = !iv_reg || process;
    assign accept     = item.valid && item.ready;

    assign result.valid      = ov_reg;
    assign result.read_data  = rd_reg;
    assign result.tx_valid   = txv_reg;
    assign result.tx_byte    = txb_reg;
    assign result.rx_dropped = drop_reg;

    always_comb
    begin
        logic en;
        logic en_new;
        logic pop1;
        logic pop2;

        en     = cr1_reg[CR1_UE] && cr1_reg[CR1_RE];
        en_new = wdata_reg[CR1_UE] && wdata_reg[CR1_RE];
        pop1   = 1'b0;
        pop2   = 1'b0;

        sr_next  = sr_reg;
        dr_next  = dr_reg;
        brr_next = brr_reg;
        cr1_next = cr1_reg;
        cr2_next = cr2_reg;
        cr3_next = cr3_reg;

        rd_next   = '0;
        txv_next  = 1'b0;
        txb_next  = '0;
        drop_next = 1'b0;

        fctrl.push      = 1'b0;
        fctrl.push_byte = rxb_reg;
        fctrl.pops      = 2'd0;

        case (func_reg)
            FUNC_READ:
            begin
                pop1 = en && !sr_reg[SR_RXNE] && fstat.avail != 2'd0;
                if (pop1)
                begin
                    dr_next          = fstat.head0;
                    sr_next[SR_RXNE] = 1'b1;
                end
                case (offset_reg)
                    OFF_SR:  rd_next = sr_next;
                    OFF_DR:
                    begin
                        rd_next = {24'd0, dr_next};
                        // second refill: next head is head1 if one byte already left
                        pop2 = en && (fstat.avail > {1'b0, pop1});
                        if (pop2)
                        begin
                            dr_next          = pop1 ? fstat.head1 : fstat.head0;
                            sr_next[SR_RXNE] = 1'b1;
                        end
                        else
                        begin
                            dr_next          = '0;
                            sr_next[SR_RXNE] = 1'b0;
                        end
                    end
                    OFF_BRR: rd_next = brr_reg;
                    OFF_CR1: rd_next = cr1_reg;
                    OFF_CR2: rd_next = cr2_reg;
                    OFF_CR3: rd_next = cr3_reg;
                    default: rd_next = '0;
                endcase
                fctrl.pops = {1'b0, pop1} + {1'b0, pop2};
            end
            FUNC_WRITE:
            begin
                case (offset_reg)
                    OFF_SR:  sr_next = wdata_reg;
                    OFF_DR:
                    begin
                        dr_next = wdata_reg[7:0];
                        if (cr1_reg[CR1_UE] && cr1_reg[CR1_TE])
                        begin
                            txv_next = 1'b1;
                            txb_next = wdata_reg[7:0];
                        end
                        sr_next[SR_TXE] = 1'b1;
                        sr_next[SR_TC]  = 1'b1;
                    end
                    OFF_BRR: brr_next = wdata_reg;
                    OFF_CR1:
                    begin
                        cr1_next = wdata_reg;
                        if (en_new && !sr_reg[SR_RXNE] && fstat.avail != 2'd0)
                        begin
                            dr_next          = fstat.head0;
                            sr_next[SR_RXNE] = 1'b1;
                            fctrl.pops       = 2'd1;
                        end
                    end
                    OFF_CR2: cr2_next = wdata_reg;
                    OFF_CR3: cr3_next = wdata_reg;
                    default:
                    begin
                    end
                endcase
            end
            FUNC_RX:
            begin
                if (fstat.full)
                begin
                    drop_next = 1'b1;
                end
                else
                begin
                    fctrl.push = 1'b1;
                end
                // an empty FIFO hands the new byte straight on
                if (en && !sr_reg[SR_RXNE] && (fstat.avail != 2'd0 || fctrl.push))
                begin
                    dr_next          = (fstat.avail != 2'd0) ? fstat.head0 : rxb_reg;
                    sr_next[SR_RXNE] = 1'b1;
                    fctrl.pops       = 2'd1;
                end
            end
            default:
            begin
            end
        endcase

        if (!process)
        begin
            sr_next    = sr_reg;
            dr_next    = dr_reg;
            brr_next   = brr_reg;
            cr1_next   = cr1_reg;
            cr2_next   = cr2_reg;
            cr3_next   = cr3_reg;
            fctrl.push = 1'b0;
            fctrl.pops = 2'd0;
        end

        iv_next = accept ? 1'b1 : (process ? 1'b0 : iv_reg);
        ov_next = process ? 1'b1 : (result.ready ? 1'b0 : ov_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg  <= 1'b0;
            ov_reg  <= 1'b0;
            sr_reg  <= '0;
            dr_reg  <= '0;
            brr_reg <= '0;
            cr1_reg <= '0;
            cr2_reg <= '0;
            cr3_reg <= '0;
        end
        else
        begin
            iv_reg  <= iv_next;
            ov_reg  <= ov_next;
            sr_reg  <= sr_next;
            dr_reg  <= dr_next;
            brr_reg <= brr_next;
            cr1_reg <= cr1_next;
            cr2_reg <= cr2_next;
            cr3_reg <= cr3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= item.func;
            offset_reg <= item.offset;
            wdata_reg  <= item.write_data;
            rxb_reg    <= item.rx_byte;
        end
        if (process)
        begin
            rd_reg   <= rd_next;
            txv_reg  <= txv_next;
            txb_reg  <= txb_next;
            drop_reg <= drop_next;
        end
    end

    urm_rx_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_rx_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (fctrl),
        .stat  (fstat)
    );

endmodule

`default_nettype wire

@@ hw/rtl/urm_checker.sv @@
`default_nettype none

module urm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] read_data,
    input wire logic        tx_valid,
    input wire logic [7:0]  tx_byte,
    input wire logic        rx_dropped
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(tx_valid)
            && $stable(tx_byte) && $stable(rx_dropped))
        else $error("result changed while stalled");

    // no byte on the line without tx_valid
    a_txb: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tx_valid |-> tx_byte == 8'd0)
        else $error("tx_byte set without tx_valid");

    // a read, a transmit and a drop come from different item kinds
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(tx_valid && rx_dropped)
            && !(read_data != 32'd0 && (tx_valid || rx_dropped)))
        else $error("result mixes item kinds");

endmodule

bind uart_register_model_with_rx_fifo urm_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .read_data  (result.read_data),
    .tx_valid   (result.tx_valid),
    .tx_byte    (result.tx_byte),
    .rx_dropped (result.rx_dropped)
);

`default_nettype wire

@@ verif/tb_uart_register_model_with_rx_fifo.sv @@
`default_nettype none

module tb_uart_register_model_with_rx_fifo
    import urm_pkg::*;
();

    localparam logic [1:0]  FUNC_NONE    = 2'd3;
    localparam logic [31:0] CR1_RXTX     = (32'd1 << CR1_UE) | (32'd1 << CR1_RE)
                                         | (32'd1 << CR1_TE);
    localparam int          TARGET_ITEMS = 1300;
    localparam int          CYCLE_LIMIT  = 500000;
    localparam int          DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [31:0] read_data;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        rx_dropped;
    } uart_reply_t;

    // Shadow of the register block: predicts one reply per accepted transfer.
    class uart_shadow;
        logic [31:0] status_r;
        logic [7:0]  data_r;
        logic [31:0] baud_r;
        logic [31:0] cr1_r;
        logic [31:0] cr2_r;
        logic [31:0] cr3_r;
        logic [7:0]  rx_store [URM_FIFO_DEPTH];
        int          wr_idx;
        int          rd_idx;
        int          held;
        uart_reply_t replies_due [$];
        int          errors;

        function new();
            status_r = '0;
            data_r   = '0;
            baud_r   = '0;
            cr1_r    = '0;
            cr2_r    = '0;
            cr3_r    = '0;
            wr_idx   = 0;
            rd_idx   = 0;
            held     = 0;
            errors   = 0;
        endfunction

        function void move_head();
            if (!cr1_r[CR1_UE] || !cr1_r[CR1_RE])
                return;
            if (status_r[SR_RXNE])
                return;
            if (held == 0)
                return;
            data_r = rx_store[rd_idx];
            rd_idx = (rd_idx + 1) % URM_FIFO_DEPTH;
            held--;
            status_r[SR_RXNE] = 1'b1;
        endfunction

        function void apply_item(logic [1:0] f, logic [7:0] o, logic [31:0] wd,
                                 logic [7:0] rb);
            uart_reply_t r;
            r = '0;
            case (f)
                FUNC_READ:
                begin
                    move_head();
                    case (o)
                        OFF_SR:  r.read_data = status_r;
                        OFF_DR:
                        begin
                            r.read_data = {24'd0, data_r};
                            status_r[SR_RXNE] = 1'b0;
                            data_r = '0;
                            move_head();
                        end
                        OFF_BRR: r.read_data = baud_r;
                        OFF_CR1: r.read_data = cr1_r;
                        OFF_CR2: r.read_data = cr2_r;
                        OFF_CR3: r.read_data = cr3_r;
                        default: r.read_data = '0;
                    endcase
                end
                FUNC_WRITE:
                begin
                    case (o)
                        OFF_SR:  status_r = wd;
                        OFF_DR:
                        begin
                            data_r = wd[7:0];
                            if (cr1_r[CR1_UE] && cr1_r[CR1_TE])
                            begin
                                r.tx_valid = 1'b1;
                                r.tx_byte  = data_r;
                            end
                            status_r[SR_TXE] = 1'b1;
                            status_r[SR_TC]  = 1'b1;
                        end
                        OFF_BRR: baud_r = wd;
                        OFF_CR1:
                        begin
                            cr1_r = wd;
                            move_head();
                        end
                        OFF_CR2: cr2_r = wd;
                        OFF_CR3: cr3_r = wd;
                        default: ;
                    endcase
                end
                FUNC_RX:
                begin
                    if (held >= URM_FIFO_DEPTH)
                        r.rx_dropped = 1'b1;
                    else
                    begin
                        rx_store[wr_idx] = rb;
                        wr_idx = (wr_idx + 1) % URM_FIFO_DEPTH;
                        held++;
                    end
                    move_head();
                end
                default: ;
            endcase
            replies_due.push_back(r);
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        task report(string what);
            $display("MISMATCH: %s", what);
            errors++;
        endtask

        task check_reply(uart_reply_t got);
            uart_reply_t exp;
            if (replies_due.size() == 0)
            begin
                report($sformatf("unexpected reply %h", got));
                return;
            end
            exp = replies_due.pop_front();
            if (got.read_data !== exp.read_data)
                report($sformatf("read_data %h, want %h", got.read_data, exp.read_data));
            if (got.tx_valid !== exp.tx_valid)
                report($sformatf("tx_valid %b, want %b", got.tx_valid, exp.tx_valid));
            if (got.tx_byte !== exp.tx_byte)
                report($sformatf("tx_byte %h, want %h", got.tx_byte, exp.tx_byte));
            if (got.rx_dropped !== exp.rx_dropped)
                report($sformatf("rx_dropped %b, want %b", got.rx_dropped, exp.rx_dropped));
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   items_done;
    int   burst_left;
    bit   flooded;

    urm_in_if  item_if ();
    urm_out_if result_if ();

    uart_shadow shadow;

    uart_register_model_with_rx_fifo i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // receiver: picks a new stall mode after each random-length run
    initial
    begin
        int mode;
        int left;
        int tick;
        result_if.ready <= 1'b0;
        mode = 0;
        left = 0;
        tick = 0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(50, 300);
            end
            left--;
            tick++;
            case (mode)
                0: result_if.ready <= 1'b1;
                1: result_if.ready <= ($urandom_range(0, 3) != 0);
                2: result_if.ready <= ((tick % 5) != 0);
                default: result_if.ready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
            shadow.check_reply({result_if.read_data, result_if.tx_valid,
                                result_if.tx_byte, result_if.rx_dropped});
    end

    function automatic logic [7:0] pick_offset();
        case ($urandom_range(0, 5))
            0: return OFF_SR;
            1: return OFF_DR;
            2: return OFF_BRR;
            3: return OFF_CR1;
            4: return OFF_CR2;
            default: return OFF_CR3;
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // one transfer on the item channel, then the burst/gap bookkeeping
    task automatic send_item(input logic [1:0] f, input logic [7:0] o,
                             input logic [31:0] wd, input logic [7:0] rb);
        int gap;
        item_if.valid      <= 1'b1;
        item_if.func       <= f;
        item_if.offset     <= o;
        item_if.write_data <= wd;
        item_if.rx_byte    <= rb;
        do
            @(posedge clk);
        while (!item_if.ready);
        shadow.apply_item(f, o, wd, rb);
        if (f != FUNC_NONE && !(f == FUNC_WRITE && !(o inside {OFF_SR, OFF_DR, OFF_BRR,
                                                                 OFF_CR1, OFF_CR2, OFF_CR3})))
            items_done++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(1, 6);
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(40, 120);
            else
                burst_left = $urandom_range(0, 12);
        end
    endtask

    task automatic wait_quiet();
        item_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (shadow.pending() != 0);
    endtask

    task automatic random_access();
        int          pick;
        logic [7:0]  o;
        logic [31:0] wd;
        pick = $urandom_range(0, 99);
        o    = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : pick_offset();
        wd   = pick_word();
        if (pick < 40)
            send_item(FUNC_READ, o, wd, 8'($urandom));
        else if (pick < 70)
        begin
            // keep the port mostly enabled so bytes keep flowing
            if (o == OFF_CR1 && $urandom_range(0, 3) != 0)
            begin
                wd = wd | (32'd1 << CR1_UE) | (32'd1 << CR1_RE);
                wd[CR1_TE] = 1'($urandom_range(0, 1));
            end
            send_item(FUNC_WRITE, o, wd, 8'($urandom));
        end
        else if (pick < 97)
            send_item(FUNC_RX, o, wd, 8'($urandom));
        else
            send_item(FUNC_NONE, o, wd, 8'($urandom));
    endtask

    // fill the FIFO past full with reception off, then drain it
    task automatic flood_and_drain();
        logic [31:0] wd;
        int          pushes;
        wd = $urandom;
        if ($urandom_range(0, 1) == 0)
            wd[CR1_RE] = 1'b0;
        else
            wd[CR1_UE] = 1'b0;
        send_item(FUNC_WRITE, OFF_CR1, wd, 8'h00);
        pushes = 0;
        while (pushes < $urandom_range(262, 275))
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(FUNC_READ, OFF_SR, $urandom, 8'h00);
            else
            begin
                send_item(FUNC_RX, 8'($urandom), $urandom, 8'($urandom));
                pushes++;
            end
        end
        send_item(FUNC_WRITE, OFF_CR1, CR1_RXTX | 32'($urandom_range(0, 3)), 8'h00);
        repeat (270)
        begin
            if ($urandom_range(0, 7) == 0)
                send_item(FUNC_READ, OFF_SR, $urandom, 8'h00);
            send_item(FUNC_READ, OFF_DR, $urandom, 8'h00);
        end
    endtask

    initial
    begin
        shadow     = new();
        items_done = 0;
        burst_left = 0;
        flooded    = 1'b0;
        item_if.valid      <= 1'b0;
        item_if.func       <= FUNC_READ;
        item_if.offset     <= '0;
        item_if.write_data <= '0;
        item_if.rx_byte    <= '0;
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_item(FUNC_READ,  OFF_SR,  32'h0, 8'h00);
        send_item(FUNC_READ,  OFF_DR,  32'h0, 8'h00);
        send_item(FUNC_WRITE, OFF_CR1, CR1_RXTX, 8'h00);
        send_item(FUNC_RX,    OFF_SR,  32'h0, 8'h00);
        send_item(FUNC_RX,    OFF_SR,  32'h0, 8'hFF);
        send_item(FUNC_READ,  OFF_SR,  32'h0, 8'h00);
        send_item(FUNC_READ,  OFF_DR,  32'h0, 8'h00);
        send_item(FUNC_READ,  OFF_DR,  32'h0, 8'h00);
        send_item(FUNC_READ,  OFF_DR,  32'h0, 8'h00);
        send_item(FUNC_WRITE, OFF_DR,  32'hFFFF_FFFF, 8'h00);
        send_item(FUNC_WRITE, OFF_CR1, 32'd1 << CR1_UE, 8'h00);
        send_item(FUNC_WRITE, OFF_DR,  32'h0000_005A, 8'h00);
        send_item(FUNC_READ,  OFF_SR,  32'h0, 8'h00);
        // status write forces the receive-full bit without data
        send_item(FUNC_WRITE, OFF_SR,  32'hFFFF_FFFF, 8'h00);
        send_item(FUNC_READ,  OFF_DR,  32'h0, 8'h00);
        send_item(FUNC_WRITE, OFF_SR,  32'h0, 8'h00);
        send_item(FUNC_WRITE, OFF_BRR, 32'hFFFF_FFFF, 8'h00);
        send_item(FUNC_READ,  OFF_BRR, 32'h0, 8'h00);
        send_item(FUNC_WRITE, OFF_CR2, 32'hFFFF_FFFF, 8'h00);
        send_item(FUNC_WRITE, OFF_CR3, 32'hFFFF_FFFF, 8'h00);
        send_item(FUNC_READ,  OFF_CR2, 32'h0, 8'h00);
        send_item(FUNC_READ,  OFF_CR3, 32'h0, 8'h00);
        send_item(FUNC_WRITE, OFF_CR1, 32'hFFFF_FFFF, 8'h00);
        send_item(FUNC_READ,  OFF_CR1, 32'h0, 8'h00);
        // unknown offsets and the unused function code
        send_item(FUNC_READ,  8'hFF,   32'h0, 8'h00);
        send_item(FUNC_WRITE, 8'h01,   32'hFFFF_FFFF, 8'h00);
        send_item(FUNC_NONE,  OFF_DR,  32'hFFFF_FFFF, 8'hFF);

        // random
        while (items_done < TARGET_ITEMS)
        begin
            if (!flooded && items_done > 300)
            begin
                wait_quiet();
                flood_and_drain();
                flooded = 1'b1;
            end
            else
            begin
                repeat ($urandom_range(40, 120))
                    random_access();
                if ($urandom_range(0, 2) == 0)
                    wait_quiet();
            end
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (shadow.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/urm_pkg.sv
hw/rtl/urm_in_if.sv
hw/rtl/urm_out_if.sv
hw/rtl/urm_ram.sv
hw/rtl/urm_rx_fifo.sv
hw/rtl/uart_register_model_with_rx_fifo.sv
hw/rtl/urm_checker.sv
verif/tb_uart_register_model_with_rx_fifo.sv
